// ===== sv/rsm_pkg.sv =====
// ============================================================================
// rsm_pkg
// Shared widths, exponent table and types for the row softmax block.
// ============================================================================
package rsm_pkg;

    localparam int SCORE_W   = 16;
    localparam int PROB_W    = 16;
    localparam int E_W       = 16;
    localparam int ACC_W     = 32;
    localparam int TAB_W     = 32;
    localparam int EXP_BITS  = 12;
    localparam int ROW_MAX_D = 64;

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic [PROB_W-1:0]         t_prob;
    typedef logic [E_W-1:0]            t_e;

    // exp(-2^b/256) in unsigned Q0.32
    function automatic logic [TAB_W-1:0] exp_bit_coef(input logic [3:0] b);
        logic [TAB_W-1:0] c;
        begin
            case (b)
                4'd0:    c = 32'd4278222805;
                4'd1:    c = 32'd4261543595;
                4'd2:    c = 32'd4228380000;
                4'd3:    c = 32'd4162825044;
                4'd4:    c = 32'd4034748382;
                4'd5:    c = 32'd3790295335;
                4'd6:    c = 32'd3344923893;
                4'd7:    c = 32'd2605029347;
                4'd8:    c = 32'd1580030169;
                4'd9:    c = 32'd581260615;
                4'd10:   c = 32'd78665070;
                4'd11:   c = 32'd1440801;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== sv/rsm_if.sv =====
// ============================================================================
// rsm_if
// Valid/ready channels for score words in and probability words out.
// ============================================================================
interface rsm_score_if;
    logic            valid;
    logic            ready;
    rsm_pkg::t_score score;
    logic            row_end;

    modport source (output valid, output score, output row_end, input ready);
    modport sink   (input valid, input score, input row_end, output ready);
endinterface

interface rsm_prob_if;
    logic           valid;
    logic           ready;
    rsm_pkg::t_prob prob;
    logic           prob_last;

    modport source (output valid, output prob, output prob_last, input ready);
    modport sink   (input valid, input prob, input prob_last, output ready);
endinterface

// ===== sv/rsm_exp.sv =====
// ============================================================================
// rsm_exp
// Iterative fixed-point exp(-delta/256): one table multiply per delta bit.
// ============================================================================
module rsm_exp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [15:0]             i_delta,
    output logic                    o_done,
    output rsm_pkg::t_e             o_e
);
    import rsm_pkg::*;

    logic [ACC_W-1:0]        r_acc, n_acc;
    logic [EXP_BITS-1:0]     r_bits;
    logic [3:0]              r_bit;
    logic                    r_busy;
    logic                    r_zero;
    logic                    r_done;
    logic [ACC_W+TAB_W-1:0]  prod;
    logic [ACC_W:0]          rnd;

    always_comb begin
        prod  = r_acc * exp_bit_coef(r_bit);
        prod  = prod + (64'd1 << 31);
        n_acc = r_bits[r_bit] ? prod[ACC_W+TAB_W-1:TAB_W] : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= ACC_W'(32'hFFFF_0000);
                r_bits <= i_delta[EXP_BITS-1:0];
                r_zero <= |i_delta[15:EXP_BITS];
                r_bit  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_bit <= r_bit + 4'd1;
                if (r_bit == 4'(EXP_BITS-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign rnd    = {1'b0, r_acc} + 33'h8000;
    assign o_e    = r_zero ? '0 : rnd[E_W+15:16];
    assign o_done = r_done;

endmodule

// ===== sv/rsm_div.sv =====
// ============================================================================
// rsm_div
// Restoring divider: floor(e*65535/sum), one quotient bit per cycle.
// ============================================================================
module rsm_div #(
    parameter int SUM_W = 22
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rsm_pkg::t_e       i_e,
    input  logic [SUM_W-1:0]  i_den,
    output logic              o_done,
    output rsm_pkg::t_prob    o_q
);
    import rsm_pkg::*;

    logic [SUM_W-1:0]   r_rem;
    logic [PROB_W-1:0]  r_low;
    logic [SUM_W-1:0]   r_den;
    logic [3:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [31:0]        num;
    logic [SUM_W:0]     trial;
    logic               qbit;

    // e*65535 without a multiplier
    assign num   = {i_e, 16'h0000} - {16'h0000, i_e};
    assign trial = {r_rem, r_low[PROB_W-1]};
    assign qbit  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // quotient < 2^16, so the high half is already below den
                r_rem  <= SUM_W'(num[31:16]);
                r_low  <= num[15:0];
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= qbit ? SUM_W'(trial - {1'b0, r_den}) : trial[SUM_W-1:0];
                r_low <= {r_low[PROB_W-2:0], qbit};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_low;

endmodule

// ===== sv/row_softmax.sv =====
// ============================================================================
// row_softmax
// Stable softmax over one buffered row of Q8.8 scores, Q0.16 outputs.
// ============================================================================
// Scores are written into a row memory at one word per cycle while the running
// maximum is tracked. The word with row_end (or the ROW_MAX-th word) closes the
// row, and input stalls until the row is done. Pass one reads each score back
// and runs the 12-step exp unit, writing the value into a second memory and
// summing it. Pass two reads each value back and runs the 16-step serial
// divider, then waits for the output register to be free under back-pressure.
module row_softmax
    import rsm_pkg::*;
#(
    parameter int ROW_MAX = ROW_MAX_D
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsm_score_if.sink    i_in,
    rsm_prob_if.source   o_out
);

    localparam int IDX_W = $clog2(ROW_MAX);
    localparam int CNT_W = $clog2(ROW_MAX + 1);
    localparam int SUM_W = IDX_W + E_W;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_ERD   = 8'b0000_0010,
        S_EXP   = 8'b0000_0100,
        S_EWAIT = 8'b0000_1000,
        S_DRD   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_DWAIT = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_n;
    logic [IDX_W-1:0]   r_idx;
    t_score             r_peak;
    logic [SUM_W-1:0]   r_total;
    t_score             r_rd_score;
    t_e                 r_rd_e;
    t_prob              r_q;
    logic               r_out_valid;
    t_prob              r_out_prob;
    logic               r_out_last;

    t_score             row_store [ROW_MAX];
    t_e                 exp_store [ROW_MAX];

    logic               in_fire;
    logic               row_close;
    logic               idx_last;
    logic [SCORE_W:0]   delta;
    logic               exp_done;
    t_e                 exp_e;
    logic               div_done;
    t_prob              div_q;
    logic               out_free;

    assign in_fire   = i_in.valid && i_in.ready;
    assign row_close = i_in.row_end || (r_count == CNT_W'(ROW_MAX - 1));
    assign idx_last  = (CNT_W'(r_idx) + CNT_W'(1)) == r_n;
    assign delta     = {r_peak[SCORE_W-1], r_peak} - {r_rd_score[SCORE_W-1], r_rd_score};
    assign out_free  = !r_out_valid || o_out.ready;

    rsm_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_EXP),
        .i_delta (delta[SCORE_W-1:0]),
        .o_done  (exp_done),
        .o_e     (exp_e)
    );

    rsm_div #(.SUM_W(SUM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV),
        .i_e     (r_rd_e),
        .i_den   (r_total),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // row memories
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            row_store[r_count[IDX_W-1:0]] <= i_in.score;
        end
        r_rd_score <= row_store[r_idx];
        if (r_state == S_EWAIT && exp_done) begin
            exp_store[r_idx] <= exp_e;
        end
        r_rd_e <= exp_store[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_n         <= '0;
            r_idx       <= '0;
            r_peak      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (r_count == '0 || i_in.score > r_peak) begin
                            r_peak <= i_in.score;
                        end
                        if (row_close) begin
                            r_n     <= r_count + CNT_W'(1);
                            r_count <= '0;
                            r_idx   <= '0;
                            r_total <= '0;
                            r_state <= S_ERD;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                S_ERD:   r_state <= S_EXP;
                S_EXP:   r_state <= S_EWAIT;
                S_EWAIT: begin
                    if (exp_done) begin
                        r_total <= r_total + SUM_W'(exp_e);
                        if (idx_last) begin
                            r_idx   <= '0;
                            r_state <= S_DRD;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                S_DRD:   r_state <= S_DIV;
                S_DIV:   r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        r_q     <= div_q;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_prob  <= r_q;
                        r_out_last  <= idx_last;
                        if (idx_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_DRD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_LOAD);
    assign o_out.valid     = r_out_valid;
    assign o_out.prob      = r_out_prob;
    assign o_out.prob_last = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(ROW_MAX))
        else $error("row count out of range");

    a_close_goes_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && row_close |=> r_state == S_ERD && r_count == '0)
        else $error("row close did not start exp pass");

    a_exp_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exp_done |-> r_state == S_EWAIT)
        else $error("exp result outside wait state");

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && out_free && idx_last |=> r_state == S_LOAD && r_out_last)
        else $error("last word did not end row");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: row softmax bench
// Drives Q8.8 score rows (directed table, a full row with no row_end, random
// rows), predicts their Q0.16 weights in the bench, checks each output in order.
// ----------------------------------------------------------------------------
module tb_top;
    import rsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LEN = 64;

    typedef struct {
        t_score score;
        logic   row_end;
        logic   chk_tab;   // table carries the expected weights for this row
        t_prob  tab_prob;  // expected weight of every entry (uniform rows)
    } t_stim;

    typedef struct {
        t_prob prob;
        logic  last;
    } t_weight;

    logic i_clk;
    logic i_rst_n;
    rsm_score_if score_ch();
    rsm_prob_if  prob_ch();

    row_softmax #(.ROW_MAX(ROW_LEN)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (score_ch.sink),
        .o_out  (prob_ch.source)
    );

    // predictor state
    t_score  row_buf[ROW_LEN];
    int      row_fill;
    t_score  peak;
    t_weight weight_q[$];
    t_prob   tab_q[$];  // typed-in expectations, paired with weight_q entries
    logic    tab_has[$];

    int  errors = 0;
    bit  stim_done = 0;
    bit  hold_req = 0;

    function automatic logic [15:0] exp_of_gap(input logic [16:0] gap);
        logic [63:0] acc;
        if (gap >= 17'd4096) return 16'd0;
        acc = 64'd65535 << 16;
        for (int b = 0; b < EXP_BITS; b++)
            if (gap[b]) acc = (acc * exp_bit_coef(b[3:0]) + 64'h8000_0000) >> 32;
        return 16'((acc + 64'h8000) >> 16);
    endfunction

    task automatic predict_score(input t_score s, input logic last_flag,
                                 input logic tabbed, input t_prob tprob);
        logic [15:0] e[ROW_LEN];
        logic [21:0] total;
        logic [31:0] p;
        if (row_fill == 0 || s > peak) peak = s;
        row_buf[row_fill] = s;
        row_fill++;
        if (!last_flag && row_fill < ROW_LEN) return;
        total = '0;
        for (int i = 0; i < row_fill; i++) begin
            e[i] = exp_of_gap(17'(int'(peak) - int'(row_buf[i])));
            total = total + e[i];
        end
        for (int i = 0; i < row_fill; i++) begin
            p = (32'(e[i]) * 32'd65535) / 32'(total);
            weight_q.push_back('{prob: t_prob'(p), last: (i == row_fill - 1)});
            tab_has.push_back(tabbed);
            tab_q.push_back(tprob);
        end
        row_fill = 0;
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    // directed table; uniform rows have weight floor(65535/n)
    t_stim dir_tab[$];

    task automatic add_row(input t_score s[$], input logic tabbed, input t_prob tp);
        foreach (s[i])
            dir_tab.push_back('{score: s[i], row_end: (i == s.size() - 1),
                                chk_tab: tabbed, tab_prob: tp});
    endtask

    // sender
    initial begin
        int n, base;
        score_ch.valid = 0;
        score_ch.score = '0;
        score_ch.row_end = 0;
        i_rst_n = 0;
        row_fill = 0;
        peak = '0;
        add_row('{t_score'(16'sd0)}, 1, 16'd65535);               // single entry
        add_row('{t_score'(16'sh8000), t_score'(16'sd32767)}, 0, 0); // extremes
        add_row('{t_score'(16'sd5), t_score'(16'sd5)}, 1, 16'd32767);   // tie
        add_row('{t_score'(16'sd100), t_score'(16'sd100 - 16'sd4095),
                  t_score'(16'sd100 - 16'sd4096), t_score'(16'sd99)}, 0, 0); // reach edge
        add_row('{t_score'(16'sh7fff), t_score'(16'sh5555), t_score'(16'shaaaa),
                  t_score'(-16'sd1), t_score'(16'sd1)}, 0, 0);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (dir_tab[k]) drive(dir_tab[k]);
        // a full row with no row_end: closes on overflow
        for (int i = 0; i < ROW_LEN; i++)
            drive('{score: t_score'(i * 7), row_end: 0, chk_tab: 0, tab_prob: 0});
        // random rows
        while (n < 170) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, ROW_LEN)
                                              : $urandom_range(1, 8);
            base = $urandom;
            for (int i = 0; i < len; i++) begin
                t_score s;
                case ($urandom_range(0, 3))
                    0: s = t_score'($urandom);
                    1: s = t_score'(base + $urandom_range(0, 4500) - 2250);
                    2: s = t_score'(base + $urandom_range(0, 600) - 300);
                    default: s = t_score'(base);
                endcase
                drive('{score: s, row_end: (i == len - 1) && (len < ROW_LEN),
                        chk_tab: 0, tab_prob: 0});
                n++;
                if (n == 120) hold_req = 1;
            end
        end
        score_ch.valid <= 0;
        stim_done = 1;
    end

    task automatic drive(input t_stim st);
        int wait_c;
        wait_c = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (wait_c > 0) begin
            score_ch.valid <= 0;
            repeat (wait_c) @(posedge i_clk);
        end
        score_ch.valid   <= 1;
        score_ch.score   <= st.score;
        score_ch.row_end <= st.row_end;
        do @(posedge i_clk); while (!score_ch.ready);
        predict_score(st.score, st.row_end, st.chk_tab, st.tab_prob);
    endtask

    // receiver
    initial begin
        int stall;
        prob_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                prob_ch.ready <= 0;
                repeat (3000) @(posedge i_clk);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                prob_ch.ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            prob_ch.ready <= 1;
            @(posedge i_clk);
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && prob_ch.valid && prob_ch.ready) begin
            if (weight_q.size() == 0) begin
                $error("unexpected word prob=%0d last=%0b", prob_ch.prob,
                       prob_ch.prob_last);
                errors++;
            end else begin
                t_weight w;
                t_prob tp;
                logic th;
                w = weight_q.pop_front();
                tp = tab_q.pop_front();
                th = tab_has.pop_front();
                if (th && tp !== w.prob) begin
                    $error("prob table: expected %0d, actual %0d", tp, w.prob);
                    errors++;
                end
                if (prob_ch.prob !== w.prob) begin
                    $error("prob: expected %0d, actual %0d", w.prob, prob_ch.prob);
                    errors++;
                end
                if (prob_ch.prob_last !== w.last) begin
                    $error("prob_last: expected %0b, actual %0b", w.last,
                           prob_ch.prob_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (weight_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
